### rtl/tile_pixel_color_stage_defines.svh
// Assertion macros for the tile pixel color stage.
`ifndef TILE_PIXEL_COLOR_STAGE_DEFINES_SVH
`define TILE_PIXEL_COLOR_STAGE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TPC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TPC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/tpc_pkg.sv
// Shared types and constants for the tile pixel color stage.
package tpc_pkg;

  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 3;

  localparam logic [ChanW-1:0] ChanMax     = 8'hff;
  localparam logic [ChanW-1:0] PrimaryRst  = 8'h80;
  localparam logic [ChanW-1:0] TintRst     = 8'h00;
  localparam logic [ChanW-1:0] StrengthRst = 8'h00;
  localparam logic [ChanW-1:0] GAlphaRst   = 8'hff;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PRIMARY_RED   = 4'd0,
    REG_PRIMARY_GREEN = 4'd1,
    REG_PRIMARY_BLUE  = 4'd2,
    REG_TINT_RED      = 4'd3,
    REG_TINT_GREEN    = 4'd4,
    REG_TINT_BLUE     = 4'd5,
    REG_TINT_STRENGTH = 4'd6,
    REG_GLOBAL_ALPHA  = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic [NumChan-1:0][ChanW-1:0] primary;
    logic [NumChan-1:0][ChanW-1:0] tint;
    logic [ChanW-1:0]              strength;
    logic [ChanW-1:0]              galpha;
  } cfg_t;

  typedef struct packed {
    logic                          drop;
    logic                          grey;
    logic                          alpha_keep;
    logic [NumChan-1:0][ChanW-1:0] src;
    logic [NumChan-1:0][ChanW-1:0] base;
    logic [NumChan-1:0][14:0]      prod;
    logic [15:0]                   alpha_prod;
    logic [ChanW-1:0]              alpha;
  } s1_t;

  typedef struct packed {
    logic                          drop;
    logic                          tint_en;
    logic [NumChan-1:0][ChanW-1:0] color;
    logic [NumChan-1:0][15:0]      keep_prod;
    logic [NumChan-1:0][15:0]      tint_prod;
    logic [ChanW-1:0]              alpha;
    logic                          faded;
  } s2_t;

endpackage

### rtl/tpc_cfg_regs.sv
// Configuration register file for the tile pixel color stage.
module tpc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tpc_pkg::CfgIndexW-1:0]        cfg_index,
  input  logic [tpc_pkg::ChanW-1:0]            cfg_data,
  output tpc_pkg::cfg_t                        cfg
);

  tpc_pkg::cfg_t cfg_r;
  tpc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tpc_pkg::REG_PRIMARY_RED:   cfg_nxt.primary[0] = cfg_data;
        tpc_pkg::REG_PRIMARY_GREEN: cfg_nxt.primary[1] = cfg_data;
        tpc_pkg::REG_PRIMARY_BLUE:  cfg_nxt.primary[2] = cfg_data;
        tpc_pkg::REG_TINT_RED:      cfg_nxt.tint[0]    = cfg_data;
        tpc_pkg::REG_TINT_GREEN:    cfg_nxt.tint[1]    = cfg_data;
        tpc_pkg::REG_TINT_BLUE:     cfg_nxt.tint[2]    = cfg_data;
        tpc_pkg::REG_TINT_STRENGTH: cfg_nxt.strength   = cfg_data;
        tpc_pkg::REG_GLOBAL_ALPHA:  cfg_nxt.galpha     = cfg_data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.primary  <= {tpc_pkg::NumChan{tpc_pkg::PrimaryRst}};
      cfg_r.tint     <= {tpc_pkg::NumChan{tpc_pkg::TintRst}};
      cfg_r.strength <= tpc_pkg::StrengthRst;
      cfg_r.galpha   <= tpc_pkg::GAlphaRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/tpc_ramp_stage.sv
// First pipeline stage: grey detect, ramp products and alpha product.
module tpc_ramp_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tpc_pkg::ChanW-1:0]     src_red,
  input  logic [tpc_pkg::ChanW-1:0]     src_green,
  input  logic [tpc_pkg::ChanW-1:0]     src_blue,
  input  logic [tpc_pkg::ChanW-1:0]     src_alpha,
  input  tpc_pkg::cfg_t                 cfg,
  output logic                          s1_valid,
  output tpc_pkg::s1_t                  s1,
  input  logic                          s1_ready
);

  logic         valid_r;
  tpc_pkg::s1_t data_r;
  tpc_pkg::s1_t data_nxt;
  logic [tpc_pkg::ChanW-1:0] level;
  logic [tpc_pkg::ChanW-1:0] mul_a [tpc_pkg::NumChan];

  assign in_ready = !valid_r || s1_ready;
  assign s1_valid = valid_r;
  assign s1       = data_r;
  assign level    = src_red;

  always_comb begin
    data_nxt.drop       = (src_alpha == '0) || (cfg.galpha == '0);
    data_nxt.grey       = (src_red != '0) && (src_red != tpc_pkg::ChanMax) &&
                          (src_red == src_green) && (src_green == src_blue);
    data_nxt.alpha_keep = (cfg.galpha == tpc_pkg::ChanMax);
    data_nxt.src        = {src_blue, src_green, src_red};
    data_nxt.alpha      = src_alpha;
    data_nxt.alpha_prod = 16'(src_alpha) * 16'(cfg.galpha);
    for (int i = 0; i < tpc_pkg::NumChan; i++) begin
      mul_a[i] = level[7] ? (tpc_pkg::ChanMax - cfg.primary[i]) : cfg.primary[i];
      data_nxt.base[i] = level[7] ? cfg.primary[i] : '0;
      data_nxt.prod[i] = 15'(mul_a[i]) * 15'(level[6:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/tpc_tint_stage.sv
// Second pipeline stage: ramp finish, alpha scaling and tint products.
module tpc_tint_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  output logic                s1_ready,
  input  tpc_pkg::s1_t        s1,
  input  tpc_pkg::cfg_t       cfg,
  output logic                s2_valid,
  output tpc_pkg::s2_t        s2,
  input  logic                s2_ready
);

  logic         valid_r;
  tpc_pkg::s2_t data_r;
  tpc_pkg::s2_t data_nxt;
  logic [tpc_pkg::ChanW-1:0] keep_w;

  assign s1_ready = !valid_r || s2_ready;
  assign s2_valid = valid_r;
  assign s2       = data_r;
  assign keep_w   = tpc_pkg::ChanMax - cfg.strength;

  always_comb begin
    data_nxt.drop    = s1.drop;
    data_nxt.tint_en = (cfg.strength != '0);
    data_nxt.alpha   = s1.alpha_keep ? s1.alpha : s1.alpha_prod[15:8];
    data_nxt.faded   = !s1.alpha_keep && (s1.alpha_prod[15:8] == '0);
    for (int i = 0; i < tpc_pkg::NumChan; i++) begin
      data_nxt.color[i] = s1.grey ? (s1.base[i] + s1.prod[i][14:7]) : s1.src[i];
      data_nxt.keep_prod[i] = 16'(data_nxt.color[i]) * 16'(keep_w);
      data_nxt.tint_prod[i] = 16'(cfg.tint[i]) * 16'(cfg.strength);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/tpc_out_stage.sv
// Third pipeline stage: tint sum and output register.
module tpc_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s2_valid,
  output logic                          s2_ready,
  input  tpc_pkg::s2_t                  s2,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpc_pkg::ChanW-1:0]     out_red,
  output logic [tpc_pkg::ChanW-1:0]     out_green,
  output logic [tpc_pkg::ChanW-1:0]     out_blue,
  output logic [tpc_pkg::ChanW-1:0]     out_alpha,
  output logic                          out_write_pixel,
  output logic                          out_alpha_faded
);

  logic valid_r;
  logic [tpc_pkg::NumChan-1:0][tpc_pkg::ChanW-1:0] color_r;
  logic [tpc_pkg::NumChan-1:0][tpc_pkg::ChanW-1:0] color_nxt;
  logic [tpc_pkg::ChanW-1:0] alpha_r;
  logic [tpc_pkg::ChanW-1:0] alpha_nxt;
  logic write_r;
  logic faded_r;
  logic [15:0] sum [tpc_pkg::NumChan];

  assign s2_ready        = !valid_r || out_ready;
  assign out_valid       = valid_r;
  assign out_red         = color_r[0];
  assign out_green       = color_r[1];
  assign out_blue        = color_r[2];
  assign out_alpha       = alpha_r;
  assign out_write_pixel = write_r;
  assign out_alpha_faded = faded_r;

  always_comb begin
    for (int i = 0; i < tpc_pkg::NumChan; i++) begin
      sum[i] = s2.keep_prod[i] + s2.tint_prod[i];
      if (s2.drop) begin
        color_nxt[i] = '0;
      end else if (s2.tint_en) begin
        color_nxt[i] = sum[i][15:8];
      end else begin
        color_nxt[i] = s2.color[i];
      end
    end
    alpha_nxt = s2.drop ? '0 : s2.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s2_ready) begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      color_r <= color_nxt;
      alpha_r <= alpha_nxt;
      write_r <= !s2.drop;
      faded_r <= !s2.drop && s2.faded;
    end
  end

endmodule

### rtl/tile_pixel_color_stage.sv
// Top level of the tile pixel color stage: config registers and three-stage pipeline.
//
//   channel  direction  handshake               word
//   in       input      in_valid / in_ready     one RGBA8 source pixel
//   out      output     out_valid / out_ready   one processed pixel and flags
//   cfg      input      cfg_valid / cfg_ready   register index and 8-bit data
//
// One pixel per clock while out_ready is high; each stage ends in a register.
// Stages: ramp and alpha multipliers, ramp finish and tint multipliers, tint sum.
// Reset is synchronous, active low; it empties the pipe and loads register defaults.
// A stall on out_ready holds each full stage; empty stages still fill.
// cfg_ready is always high.
`include "tile_pixel_color_stage_defines.svh"

module tile_pixel_color_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tpc_pkg::ChanW-1:0]         in_src_red,
  input  logic [tpc_pkg::ChanW-1:0]         in_src_green,
  input  logic [tpc_pkg::ChanW-1:0]         in_src_blue,
  input  logic [tpc_pkg::ChanW-1:0]         in_src_alpha,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tpc_pkg::ChanW-1:0]         out_red,
  output logic [tpc_pkg::ChanW-1:0]         out_green,
  output logic [tpc_pkg::ChanW-1:0]         out_blue,
  output logic [tpc_pkg::ChanW-1:0]         out_alpha,
  output logic                              out_write_pixel,
  output logic                              out_alpha_faded,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpc_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [tpc_pkg::ChanW-1:0]         cfg_data
);

  tpc_pkg::cfg_t cfg;
  tpc_pkg::s1_t  s1;
  tpc_pkg::s2_t  s2;
  logic          s1_valid;
  logic          s1_ready;
  logic          s2_valid;
  logic          s2_ready;

  tpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpc_ramp_stage u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_red   (in_src_red),
    .src_green (in_src_green),
    .src_blue  (in_src_blue),
    .src_alpha (in_src_alpha),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_ready  (s1_ready)
  );

  tpc_tint_stage u_tint (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s2_ready (s2_ready)
  );

  tpc_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .s2_valid        (s2_valid),
    .s2_ready        (s2_ready),
    .s2              (s2),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_write_pixel (out_write_pixel),
    .out_alpha_faded (out_alpha_faded)
  );

  `TPC_ASSERT_NOW(a_drop_zero, out_valid && !out_write_pixel, (out_red == '0) && (out_green == '0) && (out_blue == '0) && (out_alpha == '0) && !out_alpha_faded, "dropped word carries nonzero fields")
  `TPC_ASSERT_NOW(a_faded_alpha, out_valid && out_alpha_faded, out_write_pixel && (out_alpha == '0), "faded word inconsistent")
  `TPC_ASSERT_NOW(a_full_stall, s1_valid && s2_valid && out_valid && !out_ready, !in_ready, "input taken while pipe is full and stalled")
  `TPC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid, "output word lost under stall")

endmodule
